### sv/biss_pkg.sv
// Shared types and constants for the BiSS-C style encoder frame reader.
package biss_pkg;

  // Fixed result field widths
  localparam int POS_W   = 32;
  localparam int CRCO_W  = 6;
  localparam int LIMIT_W = 8;

  // Default frame layout
  localparam int DATA_BITS_DEF = 32;
  localparam int CRC_BITS_DEF  = 6;

  // Reset value of the start bit wait limit
  localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 8'hFF;

  // Outcome codes
  typedef enum logic [1:0] {
    OUTC_FRAME     = 2'd0,
    OUTC_NOT_READY = 2'd1,
    OUTC_TIMEOUT   = 2'd2
  } outcome_t;

  // One interface clock period as seen by the master
  typedef struct packed {
    logic start_request;
    logic data_line;
  } in_item_t;

  // One result per interface clock period
  typedef struct packed {
    logic              clock_pulse;
    logic              busy_res;
    logic              frame_done;
    outcome_t          outcome;
    logic [POS_W-1:0]  position;
    logic              error_bit;
    logic              warn_bit;
    logic [CRCO_W-1:0] crc_bits;
  } out_item_t;

endpackage

### sv/biss_seq.sv
// Frame sequencer: phase control, bit counting and receive shift registers.
module biss_seq #(
  parameter int DATA_BITS = biss_pkg::DATA_BITS_DEF,
  parameter int CRC_BITS  = biss_pkg::CRC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  biss_pkg::in_item_t            item,
  input  logic [biss_pkg::LIMIT_W-1:0]  wait_limit,
  output biss_pkg::out_item_t           result
);

  localparam int CNT_MAX = (DATA_BITS > CRC_BITS) ? DATA_BITS : CRC_BITS;
  localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(DATA_BITS - 1);
  localparam logic [CNT_W-1:0] CRC_LAST  = CNT_W'(CRC_BITS - 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ACK2  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_CDS   = 3'd3,
    PH_DATA  = 3'd4,
    PH_ERRB  = 3'd5,
    PH_WARNB = 3'd6,
    PH_CRC   = 3'd7
  } phase_t;

  phase_t                               phase, phase_next;
  logic [CNT_W-1:0]                     bit_counter, bit_counter_next;
  logic [biss_pkg::LIMIT_W-1:0]         wait_counter, wait_counter_next;
  logic [biss_pkg::POS_W-1:0]           shift_data, shift_data_next;
  logic                                 err_flag, err_flag_next;
  logic                                 warn_flag, warn_flag_next;
  logic [biss_pkg::CRCO_W-1:0]          crc_shift, crc_shift_next;

  logic line;
  assign line = item.data_line;

  // Next state and the result for this period
  always_comb begin
    phase_next        = phase;
    bit_counter_next  = bit_counter;
    wait_counter_next = wait_counter;
    shift_data_next   = shift_data;
    err_flag_next     = err_flag;
    warn_flag_next    = warn_flag;
    crc_shift_next    = crc_shift;
    result            = '0;
    result.outcome    = biss_pkg::OUTC_FRAME;

    case (phase)
      PH_IDLE: begin
        if (item.start_request) begin
          if (!line) begin
            // slave not ready, stay idle
            result.frame_done = 1'b1;
            result.outcome    = biss_pkg::OUTC_NOT_READY;
          end else begin
            result.clock_pulse = 1'b1;
            result.busy_res    = 1'b1;
            shift_data_next    = '0;
            err_flag_next      = 1'b0;
            warn_flag_next     = 1'b0;
            crc_shift_next     = '0;
            bit_counter_next   = '0;
            wait_counter_next  = '0;
            phase_next         = PH_ACK2;
          end
        end
      end
      PH_ACK2: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        phase_next         = PH_WAIT;
      end
      PH_WAIT: begin
        result.busy_res = 1'b1;
        if (line) begin
          result.clock_pulse = 1'b1;
          phase_next         = PH_CDS;
        end else if (wait_counter >= wait_limit) begin
          result.frame_done = 1'b1;
          result.outcome    = biss_pkg::OUTC_TIMEOUT;
          phase_next        = PH_IDLE;
        end else begin
          result.clock_pulse = 1'b1;
          wait_counter_next  = wait_counter + 1'b1;
        end
      end
      PH_CDS: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        bit_counter_next   = '0;
        phase_next         = PH_DATA;
      end
      PH_DATA: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        shift_data_next    = {shift_data[biss_pkg::POS_W-2:0], line};
        if (bit_counter == DATA_LAST) begin
          bit_counter_next = '0;
          phase_next       = PH_ERRB;
        end else begin
          bit_counter_next = bit_counter + 1'b1;
        end
      end
      PH_ERRB: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        err_flag_next      = line;
        phase_next         = PH_WARNB;
      end
      PH_WARNB: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        warn_flag_next     = line;
        bit_counter_next   = '0;
        phase_next         = PH_CRC;
      end
      PH_CRC: begin
        result.clock_pulse = 1'b1;
        result.busy_res    = 1'b1;
        crc_shift_next     = {crc_shift[biss_pkg::CRCO_W-2:0], line};
        if (bit_counter == CRC_LAST) begin
          // last CRC bit: report the frame
          result.frame_done = 1'b1;
          result.position   = shift_data;
          result.error_bit  = err_flag;
          result.warn_bit   = warn_flag;
          result.crc_bits   = {crc_shift[biss_pkg::CRCO_W-2:0], line};
          bit_counter_next  = '0;
          phase_next        = PH_IDLE;
        end else begin
          bit_counter_next = bit_counter + 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // State update, one period per accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_counter  <= '0;
      wait_counter <= '0;
      shift_data   <= '0;
      err_flag     <= 1'b0;
      warn_flag    <= 1'b0;
      crc_shift    <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_counter  <= bit_counter_next;
      wait_counter <= wait_counter_next;
      shift_data   <= shift_data_next;
      err_flag     <= err_flag_next;
      warn_flag    <= warn_flag_next;
      crc_shift    <= crc_shift_next;
    end
  end

endmodule

### sv/biss_encoder_frame_reader_top.sv
// Top level of the BiSS-C style encoder frame reader: config register and result register.
// Each input transfer is one interface clock period (start request and sampled slave
// data level) and yields exactly one result transfer. An item is taken every cycle
// whenever the output side does not stall: the sequencer works on it combinationally
// and its result lands in the output register on the same edge, so throughput is one
// item per cycle under that condition. The output register is the only buffer; input
// stall follows output stall while that register holds a result. The user must write
// start_wait_limit through cfg_we/cfg_data only while the block is idle; the block
// itself does not enforce this. It resets to 255.
module biss_encoder_frame_reader_top #(
  parameter int DATA_BITS = biss_pkg::DATA_BITS_DEF,
  parameter int CRC_BITS  = biss_pkg::CRC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  biss_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output biss_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [biss_pkg::LIMIT_W-1:0] cfg_data
);

  logic [biss_pkg::LIMIT_W-1:0] start_wait_limit;
  biss_pkg::out_item_t          seq_result;
  logic                         in_take;

  // Input transfer whenever the result register is free or being drained
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_wait_limit <= biss_pkg::WAIT_LIMIT_RST;
    end else if (cfg_we) begin
      start_wait_limit <= cfg_data;
    end
  end

  biss_seq #(
    .DATA_BITS (DATA_BITS),
    .CRC_BITS  (CRC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (in_take),
    .item       (in_item),
    .wait_limit (start_wait_limit),
    .result     (seq_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_item <= seq_result;
    end
  end

endmodule
